[rtl/core/sirc_pkg.sv]
// Shared types and constants for the SIRC infrared frame transmitter.
// No dependencies; the transmitter top, register bank, sequencer and testbench import this package.
package sirc_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Field widths of the frame state
    localparam int CMD_W   = 7;
    localparam int ADDR_W  = 5;
    localparam int HALF_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int SLOT_W  = 7;
    localparam int POS_W   = 5;
    localparam int PHASE_W = 2;
    localparam int WORD_W  = CMD_W + ADDR_W;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMMAND_CODE        = 3'd0,
        CFG_DEVICE_ADDRESS      = 3'd1,
        CFG_CARRIER_HALF_PERIOD = 3'd2,
        CFG_UNIT_TICKS          = 3'd3,
        CFG_FRAME_UNITS         = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic [CMD_W-1:0]  RST_COMMAND_CODE   = 7'd0;
    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS = 5'd1;
    localparam logic [HALF_W-1:0] RST_CARRIER_HALF   = 8'd105;
    localparam logic [UNIT_W-1:0] RST_UNIT_TICKS     = 16'd4800;
    localparam logic [SLOT_W-1:0] RST_FRAME_UNITS    = 7'd75;

    // Start mark length in units
    localparam logic [2:0] START_MARK_UNITS = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command_code;
        logic [ADDR_W-1:0] device_address;
        logic [HALF_W-1:0] carrier_half_period;
        logic [UNIT_W-1:0] unit_ticks;
        logic [SLOT_W-1:0] frame_units;
    } t_cfg;

    typedef struct packed {
        logic ir_out;
        logic envelope;
        logic frame_start;
    } t_result;

endpackage

[rtl/core/sirc_in_if.sv]
// Input channel interface: one tick of the time base with its run flag.
// Depends on nothing.
interface sirc_in_if;
    logic valid;
    logic ready;
    logic run;

    modport source (output valid, output run, input ready);
    modport sink   (input valid, input run, output ready);
endinterface

[rtl/core/sirc_out_if.sv]
// Output channel interface: one drive sample per tick.
// Depends on nothing.
interface sirc_out_if;
    logic valid;
    logic ready;
    logic ir_out;
    logic envelope;
    logic frame_start;

    modport source (output valid, output ir_out, output envelope, output frame_start,
                    input ready);
    modport sink   (input valid, input ir_out, input envelope, input frame_start,
                    output ready);
endinterface

[rtl/core/sirc_ir_frame_transmitter.sv]
// SIRC infrared frame transmitter, top level.
// The result of an accepted tick is registered in r_result at the edge that accepts it.
// Throughput: one tick per cycle; the output register frees itself whenever the
// result is taken, so the counters advance every cycle the sink keeps up.
// Reset: synchronous active low; registers return to their defaults, counters to zero.
// Depends on sirc_pkg, sirc_in_if, sirc_out_if, sirc_cfg_regs and sirc_frame_seq.
module sirc_ir_frame_transmitter #(
    parameter int FRAME_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sirc_in_if.sink                          i_in,
    sirc_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [sirc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sirc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sirc_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    sirc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sirc_frame_seq #(
        .FRAME_BITS (FRAME_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept),
        .i_run    (i_in.run),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Take a transaction whenever the output slot is empty or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ir_out      = r_result.ir_out;
    assign o_out.envelope    = r_result.envelope;
    assign o_out.frame_start = r_result.frame_start;

endmodule

[rtl/core/sirc_cfg_regs.sv]
// Configuration register bank of the SIRC transmitter.
// Depends on sirc_pkg for the register indexes, reset values and t_cfg.
module sirc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sirc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sirc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sirc_pkg::t_cfg                   o_cfg
);
    import sirc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COMMAND_CODE:        n_cfg.command_code        = i_cfg_data[CMD_W-1:0];
                CFG_DEVICE_ADDRESS:      n_cfg.device_address      = i_cfg_data[ADDR_W-1:0];
                CFG_CARRIER_HALF_PERIOD: n_cfg.carrier_half_period = i_cfg_data[HALF_W-1:0];
                CFG_UNIT_TICKS:          n_cfg.unit_ticks          = i_cfg_data[UNIT_W-1:0];
                CFG_FRAME_UNITS:         n_cfg.frame_units         = i_cfg_data[SLOT_W-1:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.command_code        <= RST_COMMAND_CODE;
            r_cfg.device_address      <= RST_DEVICE_ADDRESS;
            r_cfg.carrier_half_period <= RST_CARRIER_HALF;
            r_cfg.unit_ticks          <= RST_UNIT_TICKS;
            r_cfg.frame_units         <= RST_FRAME_UNITS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/sirc_frame_seq.sv]
// Frame sequencer: carrier, unit and element counters plus the per-tick result.
// Depends on sirc_pkg for widths, t_cfg and t_result.
module sirc_frame_seq #(
    parameter int FRAME_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_run,
    input  sirc_pkg::t_cfg    i_cfg,
    output sirc_pkg::t_result o_result
);
    import sirc_pkg::*;

    localparam logic [POS_W-1:0] SILENCE = POS_W'(FRAME_BITS + 2);
    localparam logic [POS_W-1:0] DATA_LAST = POS_W'(FRAME_BITS + 1);

    logic [HALF_W-1:0]  r_carrier_count, n_carrier_count;
    logic               r_carrier_level, n_carrier_level;
    logic [UNIT_W-1:0]  r_unit_count,    n_unit_count;
    logic [SLOT_W-1:0]  r_frame_slot,    n_frame_slot;
    logic [POS_W-1:0]   r_bit_position,  n_bit_position;
    logic [PHASE_W-1:0] r_bit_phase,     n_bit_phase;

    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   next_pos;
    logic [PHASE_W-1:0] next_phase;
    logic [2:0]         mark;
    logic [2:0]         elem_len;
    logic               env;
    logic [HALF_W-1:0]  half;
    logic [UNIT_W-1:0]  ut;
    logic               period_done;
    logic               unit_done;

    // Data bit b of the command/address word; zero past its end
    function automatic logic data_bit(input logic [POS_W-1:0] b, input t_cfg cfg);
        logic [WORD_W-1:0] word;
        word = {cfg.device_address, cfg.command_code};
        if (b >= POS_W'(WORD_W)) begin
            return 1'b0;
        end
        return word[b[3:0]];
    endfunction

    // Mark length, element length and envelope of the current element
    always_comb begin
        pos = (r_bit_position >= SILENCE) ? SILENCE : r_bit_position;
        if (pos == '0) begin
            mark = START_MARK_UNITS;
        end else if (pos == POS_W'(1)) begin
            mark = 3'd0;
        end else if (pos <= DATA_LAST) begin
            mark = 3'd1 + {2'b00, data_bit(pos - POS_W'(2), i_cfg)};
        end else begin
            mark = 3'd0;
        end
        if (pos == '0) begin
            elem_len = START_MARK_UNITS;
        end else if (pos == POS_W'(1)) begin
            elem_len = 3'd1;
        end else begin
            elem_len = mark + 3'd1;
        end
        env = {1'b0, r_bit_phase} < mark;
    end

    // Drive the result for this tick
    always_comb begin
        o_result.ir_out      = i_run & env & r_carrier_level;
        o_result.envelope    = i_run & env;
        o_result.frame_start = i_run & (pos == '0) & (r_bit_phase == '0)
                             & (r_unit_count == '0);
    end

    // Next state for one tick
    always_comb begin
        half        = (i_cfg.carrier_half_period == '0) ? HALF_W'(1) : i_cfg.carrier_half_period;
        ut          = (i_cfg.unit_ticks == '0) ? UNIT_W'(1) : i_cfg.unit_ticks;
        unit_done   = !(({1'b0, r_unit_count} + 17'd1) < {1'b0, ut});
        period_done = ({1'b0, r_frame_slot} + 8'd1) >= {1'b0, i_cfg.frame_units};

        n_carrier_count = r_carrier_count;
        n_carrier_level = r_carrier_level;
        n_unit_count    = r_unit_count;
        n_frame_slot    = r_frame_slot;
        n_bit_position  = r_bit_position;
        n_bit_phase     = r_bit_phase;
        next_pos        = pos;
        next_phase      = r_bit_phase + PHASE_W'(1);

        if (!i_run) begin
            n_carrier_count = '0;
            n_carrier_level = 1'b0;
            n_unit_count    = '0;
            n_frame_slot    = '0;
            n_bit_position  = '0;
            n_bit_phase     = '0;
        end else begin
            // Toggle the carrier during marks, hold it low otherwise
            if (env) begin
                if (({1'b0, r_carrier_count} + 9'd1) >= {1'b0, half}) begin
                    n_carrier_count = '0;
                    n_carrier_level = ~r_carrier_level;
                end else begin
                    n_carrier_count = r_carrier_count + HALF_W'(1);
                end
            end else begin
                n_carrier_count = '0;
                n_carrier_level = 1'b0;
            end

            // Advance unit timing and the element walk
            if (!unit_done) begin
                n_unit_count = r_unit_count + UNIT_W'(1);
            end else begin
                n_unit_count = '0;
                if ((pos < SILENCE) && (({1'b0, r_bit_phase} + 3'd1) >= elem_len)) begin
                    next_pos   = pos + POS_W'(1);
                    next_phase = '0;
                end
                if (next_pos >= SILENCE) begin
                    next_phase = '0;
                end
                if ((next_pos >= SILENCE) && period_done) begin
                    n_frame_slot   = '0;
                    n_bit_position = '0;
                    n_bit_phase    = '0;
                end else begin
                    n_bit_position = next_pos;
                    n_bit_phase    = next_phase;
                    if (r_frame_slot != '1) begin
                        n_frame_slot = r_frame_slot + SLOT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_count <= '0;
            r_carrier_level <= 1'b0;
            r_unit_count    <= '0;
            r_frame_slot    <= '0;
            r_bit_position  <= '0;
            r_bit_phase     <= '0;
        end else if (i_step) begin
            r_carrier_count <= n_carrier_count;
            r_carrier_level <= n_carrier_level;
            r_unit_count    <= n_unit_count;
            r_frame_slot    <= n_frame_slot;
            r_bit_position  <= n_bit_position;
            r_bit_phase     <= n_bit_phase;
        end
    end

endmodule

[sim/tb_sirc_ir_frame_transmitter.sv]
// Testbench for the SIRC infrared frame transmitter: drives run and idle ticks, predicts every
// drive sample in a scoreboard class and checks each output transaction field by field.
// Depends on sirc_pkg, sirc_in_if, sirc_out_if and the sirc_ir_frame_transmitter RTL.
`timescale 1ns / 100ps

module tb_sirc_ir_frame_transmitter;
    import sirc_pkg::*;

    localparam int FRAME_BITS = 12;
    localparam int SILENCE    = FRAME_BITS + 2;
    localparam int HOLD_TICKS = 60;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 64;

    // Predicts drive samples tick by tick and holds them until they come out
    class sirc_drive_scoreboard;
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  addr;
        logic [HALF_W-1:0]  half;
        logic [UNIT_W-1:0]  unit_len;
        logic [SLOT_W-1:0]  frame_len;

        logic [HALF_W-1:0]  car_cnt;
        logic               car_lvl;
        logic [UNIT_W-1:0]  unit_cnt;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   pos;
        logic [PHASE_W-1:0] phase;

        t_result expected_samples[$];
        int      mismatch_count;

        function new();
            cmd       = RST_COMMAND_CODE;
            addr      = RST_DEVICE_ADDRESS;
            half      = RST_CARRIER_HALF;
            unit_len  = RST_UNIT_TICKS;
            frame_len = RST_FRAME_UNITS;
            mismatch_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            car_cnt  = '0;
            car_lvl  = 1'b0;
            unit_cnt = '0;
            slot     = '0;
            pos      = '0;
            phase    = '0;
        endfunction

        // Mask written data to the register width; drop unknown indexes
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COMMAND_CODE:        cmd       = data[CMD_W-1:0];
                CFG_DEVICE_ADDRESS:      addr      = data[ADDR_W-1:0];
                CFG_CARRIER_HALF_PERIOD: half      = data[HALF_W-1:0];
                CFG_UNIT_TICKS:          unit_len  = data[UNIT_W-1:0];
                CFG_FRAME_UNITS:         frame_len = data[SLOT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit data_bit(int b);
            logic [WORD_W-1:0] word;
            word = {addr, cmd};
            if (b >= WORD_W)
                return 1'b0;
            return word[b];
        endfunction

        function int mark_units(int p);
            if (p == 0)
                return int'(START_MARK_UNITS);
            if (p == 1)
                return 0;
            if (p < SILENCE)
                return 1 + int'(data_bit(p - 2));
            return 0;
        endfunction

        function int elem_units(int p);
            if (p == 0)
                return int'(START_MARK_UNITS);
            if (p == 1)
                return 1;
            return mark_units(p) + 1;
        endfunction

        // Advance one tick and return the sample it produces
        function t_result next_sample(bit run);
            t_result r;
            int      p, h, u, np, nph;
            bit      env, done;
            r = '0;
            if (!run) begin
                clear_state();
                return r;
            end
            p   = (int'(pos) >= SILENCE) ? SILENCE : int'(pos);
            env = int'(phase) < mark_units(p);
            r.ir_out      = env & car_lvl;
            r.envelope    = env;
            r.frame_start = (p == 0) && (phase == '0) && (unit_cnt == '0);

            // carrier toggles only inside a mark
            h = (half == '0) ? 1 : int'(half);
            if (env) begin
                if (int'(car_cnt) + 1 >= h) begin
                    car_cnt = '0;
                    car_lvl = ~car_lvl;
                end else begin
                    car_cnt = car_cnt + 1'b1;
                end
            end else begin
                car_cnt = '0;
                car_lvl = 1'b0;
            end

            // unit timing and element sequencing
            u = (unit_len == '0) ? 1 : int'(unit_len);
            if (int'(unit_cnt) + 1 < u) begin
                unit_cnt = unit_cnt + 1'b1;
                return r;
            end
            unit_cnt = '0;
            np   = p;
            nph  = (int'(phase) + 1) & 3;
            done = int'(slot) + 1 >= int'(frame_len);
            if (p < SILENCE && int'(phase) + 1 >= elem_units(p)) begin
                np  = p + 1;
                nph = 0;
            end
            if (np >= SILENCE) begin
                nph = 0;
                if (done) begin
                    slot  = '0;
                    pos   = '0;
                    phase = '0;
                    return r;
                end
            end
            pos   = np[POS_W-1:0];
            phase = nph[PHASE_W-1:0];
            if (slot != '1)
                slot = slot + 1'b1;
            return r;
        endfunction

        function void note_tick(bit run);
            expected_samples.push_back(next_sample(run));
        endfunction

        function void check_sample(t_result got);
            t_result want;
            if (expected_samples.size() == 0) begin
                $error("output transaction with no expected sample");
                mismatch_count++;
                return;
            end
            want = expected_samples.pop_front();
            if (got.ir_out !== want.ir_out) begin
                $error("ir_out: expected %0b, got %0b", want.ir_out, got.ir_out);
                mismatch_count++;
            end
            if (got.envelope !== want.envelope) begin
                $error("envelope: expected %0b, got %0b", want.envelope, got.envelope);
                mismatch_count++;
            end
            if (got.frame_start !== want.frame_start) begin
                $error("frame_start: expected %0b, got %0b",
                       want.frame_start, got.frame_start);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sirc_in_if  tick_if ();
    sirc_out_if drive_if ();

    sirc_ir_frame_transmitter #(
        .FRAME_BITS(FRAME_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (tick_if),
        .o_out     (drive_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    sirc_drive_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int hold_left = 0;

    // Known values on every input from time zero
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        tick_if.valid  = 1'b0;
        tick_if.run    = 1'b0;
        drive_if.ready = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // Drive ready: long hold-off on request, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_TICKS;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            drive_if.ready <= 1'b0;
            hold_left--;
        end else begin
            drive_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Note accepted ticks before checking samples so ordering is fixed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tick_if.valid && tick_if.ready)
                sb.note_tick(tick_if.run);
            if (drive_if.valid && drive_if.ready)
                sb.check_sample('{ir_out: drive_if.ir_out, envelope: drive_if.envelope,
                                  frame_start: drive_if.frame_start});
        end
    end

    // Offer one tick after random idle cycles; return at the accepting edge
    task automatic send_tick(bit run);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            tick_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.run   <= run;
        do @(posedge i_clk); while (!tick_if.ready);
    endtask

    // Stop offering and wait until every expected sample is out
    task automatic drain_samples();
        @(negedge i_clk);
        tick_if.valid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx[CFG_IDX_W-1:0];
        cfg_data <= data;
        sb.set_reg(idx[CFG_IDX_W-1:0], data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly long run streaks that reach frame wrap, some short noise bursts
    task automatic send_stream(int n);
        int sent, len, k;
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 10);
            for (k = 0; k < len && sent < n; k++) begin
                send_tick(1'b1);
                sent++;
            end
            len = $urandom_range(1, 3);
            for (k = 0; k < len && sent < n; k++) begin
                send_tick(1'b0);
                sent++;
            end
        end
    endtask

    // Main sequence
    initial begin
        logic [CFG_DATA_W-1:0] half_v, unit_v, frame_v;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: first frame start, idle tick, restart
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_samples();

        // All ones to every index: masking, unknown indexes ignored
        for (int k = 0; k < (1 << CFG_IDX_W); k++)
            write_reg(k, '1);
        repeat (4) send_tick(1'b1);
        drain_samples();

        // All zeros: zero half period, zero unit length, frame shorter than data
        for (int k = 0; k <= int'(CFG_FRAME_UNITS); k++)
            write_reg(k, '0);
        repeat (14) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_samples();

        // Random phases over several settings and idling modes
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            if (ph == 0) begin
                half_v = '0; unit_v = '0; frame_v = '0;
            end else if (ph == 1) begin
                half_v = 16'd255; unit_v = 16'd1; frame_v = 16'd127;
            end else if (ph == 2) begin
                half_v = 16'd1; unit_v = 16'd2; frame_v = 16'd41;
            end else begin
                half_v  = CFG_DATA_W'(($urandom_range(0, 99) < 70) ? $urandom_range(1, 4)
                                                                  : $urandom_range(1, 255));
                unit_v  = CFG_DATA_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                                  : $urandom_range(4, 20));
                frame_v = CFG_DATA_W'(($urandom_range(0, 99) < 80) ? $urandom_range(41, 127)
                                                                  : $urandom_range(0, 40));
            end
            write_reg(CFG_COMMAND_CODE, CFG_DATA_W'($urandom_range(0, 127)));
            write_reg(CFG_DEVICE_ADDRESS, CFG_DATA_W'($urandom_range(0, 31)));
            write_reg(CFG_CARRIER_HALF_PERIOD, half_v);
            write_reg(CFG_UNIT_TICKS, unit_v);
            write_reg(CFG_FRAME_UNITS, frame_v);

            send_stream(PHASE_LEN / 2);
            // Back-pressure the output while ticks keep coming, or pause the sender
            if (ph == 1)
                hold_req = 1'b1;
            else if (ph == 3)
                drain_samples();
            send_stream(PHASE_LEN - PHASE_LEN / 2);
            drain_samples();
        end

        repeat (4) @(posedge i_clk);
        if (sb.expected_samples.size() != 0)
            $error("%0d expected samples never came out", sb.expected_samples.size());
        if (sb.mismatch_count == 0 && sb.expected_samples.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sirc_ir_frame_transmitter.f]
rtl/core/sirc_pkg.sv
rtl/core/sirc_in_if.sv
rtl/core/sirc_out_if.sv
rtl/core/sirc_cfg_regs.sv
rtl/core/sirc_frame_seq.sv
rtl/core/sirc_ir_frame_transmitter.sv
sim/tb_sirc_ir_frame_transmitter.sv
